@@ design/accel_window_activity_classifier_top_defines.svh @@
// Assertion macros for the activity classifier.
`ifndef ACCEL_WINDOW_ACTIVITY_CLASSIFIER_TOP_DEFINES_SVH
`define ACCEL_WINDOW_ACTIVITY_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define AWAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define AWAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AWAC_ASSERT(lbl, prop, msg)
`define AWAC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/awac_pkg.sv @@
`default_nettype none
package awac_pkg;

	localparam int CNT_W  = 6;
	localparam int SUM_W  = 22;
	localparam int SQ_W   = 36;
	localparam int V_W    = 46;
	localparam int MA_W   = 37;
	localparam int MB_W   = 23;
	localparam int PROD_W = 60;
	localparam int N2_W   = 12;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 32;

	localparam logic [IDX_W-1:0] REG_STEP_LEVEL   = 3'd0;
	localparam logic [IDX_W-1:0] REG_REST_VAR     = 3'd1;
	localparam logic [IDX_W-1:0] REG_SWING_CHECK  = 3'd2;
	localparam logic [IDX_W-1:0] REG_WALK_VAR     = 3'd3;
	localparam logic [IDX_W-1:0] REG_RUN_VAR      = 3'd4;
	localparam logic [IDX_W-1:0] REG_WALK_SWING   = 3'd5;
	localparam logic [IDX_W-1:0] REG_SWIM_SWING   = 3'd6;

	typedef enum logic [2:0] {
		CLS_REST = 3'd0,
		CLS_WALK = 3'd1,
		CLS_RUN  = 3'd2,
		CLS_PLAY = 3'd3,
		CLS_SWIM = 3'd4
	} cls_t;

	typedef struct packed {
		logic [14:0] step_level;
		logic [31:0] rest_var_limit;
		logic [31:0] swing_check_limit;
		logic [31:0] walk_var_limit;
		logic [31:0] run_var_limit;
		logic [15:0] walk_swing_min;
		logic [15:0] swim_swing_max;
	} cfg_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_X,
		MUL_Y,
		MUL_Z,
		MUL_NN,
		MUL_NSQ0,
		MUL_NSQ1,
		MUL_NSQ2,
		MUL_SS0,
		MUL_SS1,
		MUL_SS2,
		MUL_LIM_REST,
		MUL_LIM_SWING,
		MUL_LIM_WALK,
		MUL_LIM_RUN
	} mul_sel_t;

	typedef enum logic [3:0] {
		ACC_NONE,
		ACC_SQ0,
		ACC_SQ1,
		ACC_SQ2,
		ACC_N2,
		ACC_VSET,
		ACC_VADD,
		ACC_VSUB,
		ACC_F_REST,
		ACC_F_SWING,
		ACC_F_WALK,
		ACC_F_RUN
	} acc_sel_t;

	typedef struct packed {
		logic     load;
		logic     upd;
		mul_sel_t mul;
		acc_sel_t acc;
		logic     emit;
	} dp_cmd_t;

	typedef struct packed {
		logic             win_full;
		logic             last;
		logic [CNT_W-1:0] count;
	} dp_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_MA,
		ST_C0,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_C4,
		ST_C5,
		ST_C6,
		ST_C7,
		ST_C8,
		ST_C9,
		ST_C10,
		ST_C11,
		ST_EMIT
	} state_t;

	// millicalorie increment per class
	function automatic logic [4:0] energy_inc(input cls_t c);
		logic [4:0] r;
		case (c)
			CLS_REST: r = 5'd2;
			CLS_WALK: r = 5'd8;
			CLS_RUN:  r = 5'd23;
			CLS_PLAY: r = 5'd14;
			CLS_SWIM: r = 5'd17;
			default:  r = 5'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/accel_window_activity_classifier_top.sv @@
// A counted sample is accepted in idle; before the next acceptance, one shared multiplier
// squares x, y and z in turn and a stage accumulates each.
// A window-closing item adds window-end math on that multiplier (states C0 to C11) and an
// emit state that waits while the output is stalled; a closing item on a full window goes straight to C0.
// Reset (arst_n low, asynchronous) restores register defaults, clears statistics, totals
// and step detector, and drops out_valid.
`default_nettype none
`include "accel_window_activity_classifier_top_defines.svh"
module accel_window_activity_classifier_top #(
	parameter int WINDOW = 52
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [awac_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [awac_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [15:0]         accel_x,
	input  wire logic signed [15:0]         accel_y,
	input  wire logic signed [15:0]         accel_z,
	input  wire logic                       last_sample,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [2:0]                      activity,
	output logic [31:0]                     steps,
	output logic [31:0]                     calories
);
	import awac_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	awac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	awac_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.out_stall   (out_stall),
		.sts         (sts),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.cmd         (cmd)
	);

	awac_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.last_sample (last_sample),
		.sts         (sts),
		.activity    (activity),
		.steps       (steps),
		.calories    (calories)
	);

	`AWAC_ASSERT(a_emit_out_free, cmd.emit |-> (!out_valid || !out_stall), "result overwritten")
	`AWAC_ASSERT_NEXT(a_emit_clears, cmd.emit, sts.count == '0, "window not cleared")
	`AWAC_ASSERT(a_count_bound, sts.count <= CNT_W'(WINDOW), "sample count past window")

endmodule
`default_nettype wire

@@ design/awac_cfg.sv @@
`default_nettype none
module awac_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [awac_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [awac_pkg::CFG_W-1:0] cfg_data,
	output awac_pkg::cfg_t                  cfg
);
	import awac_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_level        <= 15'd800;
			cfg_q.rest_var_limit    <= 32'd5000;
			cfg_q.swing_check_limit <= 32'd50000;
			cfg_q.walk_var_limit    <= 32'd200000;
			cfg_q.run_var_limit     <= 32'd600000;
			cfg_q.walk_swing_min    <= 16'd3000;
			cfg_q.swim_swing_max    <= 16'd8000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_LEVEL:  cfg_q.step_level        <= cfg_data[14:0];
				REG_REST_VAR:    cfg_q.rest_var_limit    <= cfg_data;
				REG_SWING_CHECK: cfg_q.swing_check_limit <= cfg_data;
				REG_WALK_VAR:    cfg_q.walk_var_limit    <= cfg_data;
				REG_RUN_VAR:     cfg_q.run_var_limit     <= cfg_data;
				REG_WALK_SWING:  cfg_q.walk_swing_min    <= cfg_data[15:0];
				REG_SWIM_SWING:  cfg_q.swim_swing_max    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ design/awac_ctrl.sv @@
`default_nettype none
module awac_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        last_sample,
	input  wire logic        out_stall,
	input  awac_pkg::dp_sts_t sts,
	output logic             in_stall,
	output logic             out_valid,
	output awac_pkg::dp_cmd_t cmd
);
	import awac_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!sts.win_full)
						state_d = ST_MX;
					else if (last_sample)
						state_d = ST_C0;
				end
			end
			ST_MX:  state_d = ST_MY;
			ST_MY:  state_d = ST_MZ;
			ST_MZ:  state_d = ST_MA;
			ST_MA:  state_d = sts.last ? ST_C0 : ST_IDLE;
			ST_C0:  state_d = ST_C1;
			ST_C1:  state_d = ST_C2;
			ST_C2:  state_d = ST_C3;
			ST_C3:  state_d = ST_C4;
			ST_C4:  state_d = ST_C5;
			ST_C5:  state_d = ST_C6;
			ST_C6:  state_d = ST_C7;
			ST_C7:  state_d = ST_C8;
			ST_C8:  state_d = ST_C9;
			ST_C9:  state_d = ST_C10;
			ST_C10: state_d = ST_C11;
			ST_C11: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// window-end sequence: n*n, then per axis n*sumsq - sum^2, then four limit*n^2 compares
	always_comb begin
		cmd      = '0;
		cmd.mul  = MUL_NONE;
		cmd.acc  = ACC_NONE;
		case (state_q)
			ST_IDLE: cmd.load = accept;
			ST_MX: begin
				cmd.upd = 1'b1;
				cmd.mul = MUL_X;
			end
			ST_MY: begin
				cmd.mul = MUL_Y;
				cmd.acc = ACC_SQ0;
			end
			ST_MZ: begin
				cmd.mul = MUL_Z;
				cmd.acc = ACC_SQ1;
			end
			ST_MA:  cmd.acc = ACC_SQ2;
			ST_C0:  cmd.mul = MUL_NN;
			ST_C1: begin
				cmd.acc = ACC_N2;
				cmd.mul = MUL_NSQ0;
			end
			ST_C2: begin
				cmd.acc = ACC_VSET;
				cmd.mul = MUL_SS0;
			end
			ST_C3: begin
				cmd.acc = ACC_VSUB;
				cmd.mul = MUL_NSQ1;
			end
			ST_C4: begin
				cmd.acc = ACC_VADD;
				cmd.mul = MUL_SS1;
			end
			ST_C5: begin
				cmd.acc = ACC_VSUB;
				cmd.mul = MUL_NSQ2;
			end
			ST_C6: begin
				cmd.acc = ACC_VADD;
				cmd.mul = MUL_SS2;
			end
			ST_C7: begin
				cmd.acc = ACC_VSUB;
				cmd.mul = MUL_LIM_REST;
			end
			ST_C8: begin
				cmd.acc = ACC_F_REST;
				cmd.mul = MUL_LIM_SWING;
			end
			ST_C9: begin
				cmd.acc = ACC_F_SWING;
				cmd.mul = MUL_LIM_WALK;
			end
			ST_C10: begin
				cmd.acc = ACC_F_WALK;
				cmd.mul = MUL_LIM_RUN;
			end
			ST_C11:  cmd.acc = ACC_F_RUN;
			ST_EMIT: cmd.emit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.emit || (out_valid_q && out_stall);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ design/awac_dp.sv @@
`default_nettype none
module awac_dp #(
	parameter int WINDOW = 52
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  awac_pkg::cfg_t          cfg,
	input  awac_pkg::dp_cmd_t       cmd,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic               last_sample,
	output awac_pkg::dp_sts_t       sts,
	output logic [2:0]              activity,
	output logic [31:0]             steps,
	output logic [31:0]             calories
);
	import awac_pkg::*;

	logic signed [15:0]       x_q, y_q, z_q;
	logic                     last_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q [3];
	logic [SQ_W-1:0]          sumsq_q [3];
	logic signed [15:0]       zlow_q, zhigh_q;
	logic                     armed_q;
	logic [31:0]              step_total_q;
	logic [31:0]              energy_q;
	logic [N2_W-1:0]          n2_q;
	logic [V_W-1:0]           v_q;
	logic                     lt_rest_q, lt_swing_q, lt_walk_q, lt_run_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [2:0]               activity_q;
	logic [31:0]              steps_q;
	logic [31:0]              calories_q;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [16:0]       z17, lvl17;
	logic signed [17:0]       p2p;
	logic signed [17:0]       walk_min18, swim_max18;
	logic [V_W-1:0]           prod_v;
	cls_t                     cls;
	logic [31:0]              energy_next;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul)
			MUL_X: begin
				mul_a = {{(MA_W-16){x_q[15]}}, x_q};
				mul_b = {{(MB_W-16){x_q[15]}}, x_q};
			end
			MUL_Y: begin
				mul_a = {{(MA_W-16){y_q[15]}}, y_q};
				mul_b = {{(MB_W-16){y_q[15]}}, y_q};
			end
			MUL_Z: begin
				mul_a = {{(MA_W-16){z_q[15]}}, z_q};
				mul_b = {{(MB_W-16){z_q[15]}}, z_q};
			end
			MUL_NN: begin
				mul_a = {{(MA_W-CNT_W){1'b0}}, count_q};
				mul_b = {{(MB_W-CNT_W){1'b0}}, count_q};
			end
			MUL_NSQ0: begin
				mul_a = {{(MA_W-SQ_W){1'b0}}, sumsq_q[0]};
				mul_b = {{(MB_W-CNT_W){1'b0}}, count_q};
			end
			MUL_NSQ1: begin
				mul_a = {{(MA_W-SQ_W){1'b0}}, sumsq_q[1]};
				mul_b = {{(MB_W-CNT_W){1'b0}}, count_q};
			end
			MUL_NSQ2: begin
				mul_a = {{(MA_W-SQ_W){1'b0}}, sumsq_q[2]};
				mul_b = {{(MB_W-CNT_W){1'b0}}, count_q};
			end
			MUL_SS0: begin
				mul_a = {{(MA_W-SUM_W){sum_q[0][SUM_W-1]}}, sum_q[0]};
				mul_b = {{(MB_W-SUM_W){sum_q[0][SUM_W-1]}}, sum_q[0]};
			end
			MUL_SS1: begin
				mul_a = {{(MA_W-SUM_W){sum_q[1][SUM_W-1]}}, sum_q[1]};
				mul_b = {{(MB_W-SUM_W){sum_q[1][SUM_W-1]}}, sum_q[1]};
			end
			MUL_SS2: begin
				mul_a = {{(MA_W-SUM_W){sum_q[2][SUM_W-1]}}, sum_q[2]};
				mul_b = {{(MB_W-SUM_W){sum_q[2][SUM_W-1]}}, sum_q[2]};
			end
			MUL_LIM_REST: begin
				mul_a = {{(MA_W-32){1'b0}}, cfg.rest_var_limit};
				mul_b = {{(MB_W-N2_W){1'b0}}, n2_q};
			end
			MUL_LIM_SWING: begin
				mul_a = {{(MA_W-32){1'b0}}, cfg.swing_check_limit};
				mul_b = {{(MB_W-N2_W){1'b0}}, n2_q};
			end
			MUL_LIM_WALK: begin
				mul_a = {{(MA_W-32){1'b0}}, cfg.walk_var_limit};
				mul_b = {{(MB_W-N2_W){1'b0}}, n2_q};
			end
			MUL_LIM_RUN: begin
				mul_a = {{(MA_W-32){1'b0}}, cfg.run_var_limit};
				mul_b = {{(MB_W-N2_W){1'b0}}, n2_q};
			end
			default: ;
		endcase
	end

	// all products here are non-negative and below 2^45
	assign prod_v = prod_q[V_W-1:0];

	assign z17   = {z_q[15], z_q};
	assign lvl17 = {2'b00, cfg.step_level};

	assign p2p        = {{2{zhigh_q[15]}}, zhigh_q} - {{2{zlow_q[15]}}, zlow_q};
	assign walk_min18 = {2'b00, cfg.walk_swing_min};
	assign swim_max18 = {2'b00, cfg.swim_swing_max};

	always_comb begin
		if (lt_rest_q)
			cls = CLS_REST;
		else if (lt_swing_q)
			cls = (p2p > walk_min18) ? CLS_WALK : CLS_REST;
		else if (lt_walk_q)
			cls = CLS_WALK;
		else if (lt_run_q)
			cls = CLS_RUN;
		else
			cls = (p2p < swim_max18) ? CLS_SWIM : CLS_PLAY;
	end

	assign energy_next = energy_q + {27'd0, energy_inc(cls)};

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			x_q    <= accel_x;
			y_q    <= accel_y;
			z_q    <= accel_z;
			last_q <= last_sample;
		end
		case (cmd.acc)
			ACC_N2:      n2_q       <= prod_q[N2_W-1:0];
			ACC_VSET:    v_q        <= prod_v;
			ACC_VADD:    v_q        <= v_q + prod_v;
			ACC_VSUB:    v_q        <= v_q - prod_v;
			ACC_F_REST:  lt_rest_q  <= (v_q < prod_v);
			ACC_F_SWING: lt_swing_q <= (v_q < prod_v);
			ACC_F_WALK:  lt_walk_q  <= (v_q < prod_v);
			ACC_F_RUN:   lt_run_q   <= (v_q < prod_v);
			default: ;
		endcase
		if (cmd.emit) begin
			activity_q <= cls;
			steps_q    <= step_total_q;
			calories_q <= energy_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			sum_q[0]     <= '0;
			sum_q[1]     <= '0;
			sum_q[2]     <= '0;
			sumsq_q[0]   <= '0;
			sumsq_q[1]   <= '0;
			sumsq_q[2]   <= '0;
			zlow_q       <= 16'sh7FFF;
			zhigh_q      <= 16'sh8000;
			armed_q      <= 1'b0;
			step_total_q <= '0;
			energy_q     <= '0;
		end else begin
			if (cmd.upd) begin
				count_q  <= count_q + 1'b1;
				sum_q[0] <= sum_q[0] + {{(SUM_W-16){x_q[15]}}, x_q};
				sum_q[1] <= sum_q[1] + {{(SUM_W-16){y_q[15]}}, y_q};
				sum_q[2] <= sum_q[2] + {{(SUM_W-16){z_q[15]}}, z_q};
				if (z_q < zlow_q)
					zlow_q <= z_q;
				if (z_q > zhigh_q)
					zhigh_q <= z_q;
				// hysteresis: arm above +level, count on falling below -level
				if (!armed_q && (z17 > lvl17)) begin
					armed_q <= 1'b1;
				end else if (armed_q && (z17 < -lvl17)) begin
					armed_q      <= 1'b0;
					step_total_q <= step_total_q + 32'd1;
				end
			end
			case (cmd.acc)
				ACC_SQ0: sumsq_q[0] <= sumsq_q[0] + prod_q[SQ_W-1:0];
				ACC_SQ1: sumsq_q[1] <= sumsq_q[1] + prod_q[SQ_W-1:0];
				ACC_SQ2: sumsq_q[2] <= sumsq_q[2] + prod_q[SQ_W-1:0];
				default: ;
			endcase
			if (cmd.emit) begin
				energy_q   <= energy_next;
				count_q    <= '0;
				sum_q[0]   <= '0;
				sum_q[1]   <= '0;
				sum_q[2]   <= '0;
				sumsq_q[0] <= '0;
				sumsq_q[1] <= '0;
				sumsq_q[2] <= '0;
				zlow_q     <= 16'sh7FFF;
				zhigh_q    <= 16'sh8000;
			end
		end
	end

	assign sts.win_full = (count_q >= CNT_W'(WINDOW));
	assign sts.last     = last_q;
	assign sts.count    = count_q;

	assign activity = activity_q;
	assign steps    = steps_q;
	assign calories = calories_q;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
	import awac_pkg::*;

	localparam int WIN_LEN        = 52;
	localparam int SETTLE_CYCLES  = 30;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               last;
		bit                 hold;  // wait until all pending summaries are out
	} sample_t;

	typedef struct {
		cls_t        activity;
		logic [31:0] steps;
		logic [31:0] calories;
	} summary_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic [IDX_W-1:0]   cfg_index   = '0;
	logic [CFG_W-1:0]   cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic signed [15:0] accel_x     = '0;
	logic signed [15:0] accel_y     = '0;
	logic signed [15:0] accel_z     = '0;
	logic               last_sample = 1'b0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [2:0]         activity;
	logic [31:0]        steps;
	logic [31:0]        calories;

	sample_t  pending_samples[$];
	summary_t expected_summaries[$];
	sample_t  in_flight;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int fail_count     = 0;
	int quiet_cycles   = 0;

	// predictor state
	cfg_t               shadow_cfg;
	logic [5:0]         n_counted;
	logic signed [21:0] sum_xyz[3];
	logic [35:0]        sumsq_xyz[3];
	logic signed [15:0] z_floor;
	logic signed [15:0] z_peak;
	bit                 armed;
	logic [31:0]        step_tally;
	logic [31:0]        mcal_total;

	accel_window_activity_classifier_top #(
		.WINDOW(WIN_LEN)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.last_sample(last_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.activity   (activity),
		.steps      (steps),
		.calories   (calories)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_window();
		int a;
		n_counted = '0;
		for (a = 0; a < 3; a++) begin
			sum_xyz[a]   = '0;
			sumsq_xyz[a] = '0;
		end
		z_floor = 16'sh7FFF;
		z_peak  = 16'sh8000;
	endfunction

	function automatic void reset_model();
		shadow_cfg.step_level        = 15'd800;
		shadow_cfg.rest_var_limit    = 32'd5000;
		shadow_cfg.swing_check_limit = 32'd50000;
		shadow_cfg.walk_var_limit    = 32'd200000;
		shadow_cfg.run_var_limit     = 32'd600000;
		shadow_cfg.walk_swing_min    = 16'd3000;
		shadow_cfg.swim_swing_max    = 16'd8000;
		clear_window();
		armed      = 1'b0;
		step_tally = '0;
		mcal_total = '0;
	endfunction

	function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		case (idx)
			REG_STEP_LEVEL:  shadow_cfg.step_level        = data[14:0];
			REG_REST_VAR:    shadow_cfg.rest_var_limit    = data;
			REG_SWING_CHECK: shadow_cfg.swing_check_limit = data;
			REG_WALK_VAR:    shadow_cfg.walk_var_limit    = data;
			REG_RUN_VAR:     shadow_cfg.run_var_limit     = data;
			REG_WALK_SWING:  shadow_cfg.walk_swing_min    = data[15:0];
			REG_SWIM_SWING:  shadow_cfg.swim_swing_max    = data[15:0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] mcal_for(input cls_t c);
		case (c)
			CLS_REST: return 32'd2;
			CLS_WALK: return 32'd8;
			CLS_RUN:  return 32'd23;
			CLS_PLAY: return 32'd14;
			default:  return 32'd17;
		endcase
	endfunction

	// exact variance test: sum over axes of (n*sumsq - sum^2) against limit*n^2
	function automatic cls_t classify_window();
		longint n, n2, var_sum, p2p, s;
		int a;
		n = longint'(n_counted);
		n2 = n * n;
		var_sum = 0;
		for (a = 0; a < 3; a++) begin
			s = longint'(sum_xyz[a]);
			var_sum += n * longint'(sumsq_xyz[a]) - s * s;
		end
		p2p = longint'(z_peak) - longint'(z_floor);
		if (var_sum < longint'(shadow_cfg.rest_var_limit) * n2)
			return CLS_REST;
		if (var_sum < longint'(shadow_cfg.swing_check_limit) * n2)
			return (p2p > longint'(shadow_cfg.walk_swing_min)) ? CLS_WALK : CLS_REST;
		if (var_sum < longint'(shadow_cfg.walk_var_limit) * n2)
			return CLS_WALK;
		if (var_sum < longint'(shadow_cfg.run_var_limit) * n2)
			return CLS_RUN;
		return (p2p < longint'(shadow_cfg.swim_swing_max)) ? CLS_SWIM : CLS_PLAY;
	endfunction

	function automatic void track_sample(input sample_t s);
		logic signed [15:0] v[3];
		int a, zv, lvl;
		summary_t r;
		v[0] = s.x;
		v[1] = s.y;
		v[2] = s.z;
		if (n_counted < WIN_LEN) begin
			for (a = 0; a < 3; a++) begin
				sum_xyz[a]   = sum_xyz[a] + v[a];
				sumsq_xyz[a] = sumsq_xyz[a] + 36'(int'(v[a]) * int'(v[a]));
			end
			zv  = int'(s.z);
			lvl = int'(shadow_cfg.step_level);
			if (zv < int'(z_floor))
				z_floor = s.z;
			if (zv > int'(z_peak))
				z_peak = s.z;
			if (!armed && zv > lvl) begin
				armed = 1'b1;
			end else if (armed && zv < -lvl) begin
				armed = 1'b0;
				step_tally = step_tally + 32'd1;
			end
			n_counted = n_counted + 6'd1;
		end
		if (s.last) begin
			r.activity = classify_window();
			mcal_total = mcal_total + mcal_for(r.activity);
			r.steps    = step_tally;
			r.calories = mcal_total;
			expected_summaries.push_back(r);
			clear_window();
		end
	endfunction

	function automatic void push_sample(input int x, input int y, input int z, input bit last);
		sample_t s;
		s.x    = 16'(x);
		s.y    = 16'(y);
		s.z    = 16'(z);
		s.last = last;
		s.hold = 1'b0;
		pending_samples.push_back(s);
	endfunction

	// center +/- amp, saturated to 16 bits
	function automatic logic signed [15:0] jitter(input int center, input int amp);
		int v;
		v = center + int'($urandom_range(2 * amp, 0)) - amp;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic void queue_window(input int len, input bit hold_first);
		int style, lvl, a, i, zsign, mag;
		int amp[3];
		int base[3];
		bit zswing;
		sample_t s;
		style  = $urandom_range(99);
		lvl    = int'(shadow_cfg.step_level);
		zswing = ($urandom_range(99) < 40);
		zsign  = 1;
		for (a = 0; a < 3; a++) begin
			case ($urandom_range(3))
				0:       amp[a] = $urandom_range(60);
				1:       amp[a] = $urandom_range(400);
				2:       amp[a] = $urandom_range(1500);
				default: amp[a] = $urandom_range(6000);
			endcase
			base[a] = int'($urandom_range(16000)) - 8000;
		end
		for (i = 0; i < len; i++) begin
			if (style < 15) begin
				s.x = 16'($urandom);
				s.y = 16'($urandom);
				s.z = 16'($urandom);
			end else begin
				s.x = jitter(base[0], amp[0]);
				s.y = jitter(base[1], amp[1]);
				if (zswing) begin
					// hover around the step level so both sides of it are hit
					if ($urandom_range(1) != 0)
						zsign = -zsign;
					mag = lvl + int'($urandom_range(400)) - 100;
					s.z = jitter(zsign * mag, 0);
				end else begin
					s.z = jitter(base[2], amp[2]);
				end
			end
			s.last = (i == len - 1);
			s.hold = hold_first && (i == 0);
			pending_samples.push_back(s);
		end
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
	endtask

	task automatic program_all(input logic [31:0] data);
		int k;
		for (k = int'(REG_STEP_LEVEL); k <= int'(REG_SWIM_SWING); k++)
			write_reg(IDX_W'(k), data);
	endtask

	task automatic program_random(input bit ordered);
		logic [31:0] lim[4];
		int k;
		lim[0] = $urandom_range(20000);
		for (k = 1; k < 4; k++)
			lim[k] = ordered ? lim[k-1] + $urandom_range(300000) : $urandom_range(1000000);
		write_reg(REG_STEP_LEVEL, {17'($urandom), 15'($urandom_range(3000))});
		write_reg(REG_REST_VAR, lim[0]);
		write_reg(REG_SWING_CHECK, lim[1]);
		write_reg(REG_WALK_VAR, lim[2]);
		write_reg(REG_RUN_VAR, lim[3]);
		write_reg(REG_WALK_SWING, {16'($urandom), 16'($urandom_range(5000))});
		write_reg(REG_SWIM_SWING, {16'($urandom), 16'($urandom_range(20000))});
		write_reg(REG_NONE, $urandom);
	endtask

	// everything sent, every summary back, and time for a non-closing item to finish
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_summaries.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(input int items, input int hold_pct);
		int done, len, r;
		done = 0;
		while (done < items) begin
			r = $urandom_range(99);
			if (r < 80)
				len = $urandom_range(6, 1);
			else if (r < 95)
				len = $urandom_range(20, 7);
			else
				len = $urandom_range(60, 45);
			queue_window(len, (done == 0 && hold_pct > 0) || $urandom_range(99) < hold_pct);
			done += len;
		end
		wait_drained();
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				track_sample(in_flight);
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() != 0
				    && !(pending_samples[0].hold && expected_summaries.size() != 0)
				    && $urandom_range(99) >= send_idle_pct) begin
					in_flight = pending_samples.pop_front();
					accel_x     <= in_flight.x;
					accel_y     <= in_flight.y;
					accel_z     <= in_flight.z;
					last_sample <= in_flight.last;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		summary_t e;
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (expected_summaries.size() == 0) begin
					$error("unexpected summary: activity %0d steps %0d calories %0d",
						activity, steps, calories);
					fail_count++;
				end else begin
					e = expected_summaries.pop_front();
					if (activity !== 3'(e.activity)) begin
						$error("activity mismatch: expected %0d, got %0d", e.activity, activity);
						fail_count++;
					end
					if (steps !== e.steps) begin
						$error("steps mismatch: expected %0d, got %0d", e.steps, steps);
						fail_count++;
					end
					if (calories !== e.calories) begin
						$error("calories mismatch: expected %0d, got %0d", e.calories, calories);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int i;
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset config
		push_sample(0, 0, 800, 0);        // exactly at level: no arm
		push_sample(0, 0, -800, 0);
		push_sample(0, 0, 0, 1);
		push_sample(0, 0, 801, 0);        // two steps
		push_sample(0, 0, -801, 0);
		push_sample(0, 0, 20000, 0);
		push_sample(0, 0, -20000, 1);
		push_sample(-32768, 32767, -32768, 0);
		push_sample(32767, -32768, 32767, 1);  // leaves detector armed
		push_sample(5, -5, 123, 1);       // one-item window
		push_sample(1000, 0, 0, 0);       // swim
		push_sample(-1000, 0, 0, 1);
		push_sample(600, 0, 0, 0);        // run
		push_sample(-600, 0, 0, 1);
		push_sample(300, 0, 0, 0);        // walk
		push_sample(-300, 0, 0, 1);
		push_sample(0, 0, 100, 0);        // low band, small swing: rest
		push_sample(0, 0, -100, 1);
		// overlong window: trailing samples must not count nor step
		for (i = 0; i < WIN_LEN + 3; i++) begin
			if (i < WIN_LEN)
				push_sample((i % 2 != 0) ? 50 : -50, i, 0, 0);
			else
				push_sample(0, 0, (i % 2 != 0) ? 30000 : -30000, i == WIN_LEN + 2);
		end
		wait_drained();

		run_random(130, 0);

		send_idle_pct = 58;
		program_random(1'b1);
		run_random(130, 0);

		send_idle_pct  = 0;
		recv_stall_pct = 58;
		program_all(32'h0000_0000);
		run_random(110, 0);

		send_idle_pct  = 33;
		recv_stall_pct = 33;
		program_all(32'hFFFF_FFFF);
		run_random(110, 0);

		program_random(1'b1);
		run_random(130, 25);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		program_random(1'b0);
		run_random(120, 0);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
